// File: hdl/frame_receiver_crc16_check_core_assert.svh
// Assertion macros for the framed packet receiver.
// Included by the modules that carry assertions; no other dependencies.
`ifndef FRAME_RECEIVER_CRC16_CHECK_CORE_ASSERT_SVH
`define FRAME_RECEIVER_CRC16_CHECK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FRC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("frc assertion failed");
`define FRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("frc assertion failed");
`else
`define FRC_ASSERT(lbl, clk, rst, prop)
`define FRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/frc_pkg.sv
// Shared types, constants and the CRC digit step for the framed packet receiver.
// No dependencies.
package frc_pkg;

  localparam int STORE_DEPTH_DEF = 128;
  localparam int MAX_PAYLOAD_DEF = 56;

  localparam logic [7:0]  SOF_BYTE     = 8'hAA;
  localparam logic [7:0]  EOF_BYTE     = 8'h55;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [5:0]  LIMIT_RESET  = 6'd56;
  localparam logic [5:0]  LEN_SAT      = 6'd63;

  // Frame layout, as byte positions in the store
  localparam int SOF_LEN     = 4;
  localparam int CMD_POS     = 4;
  localparam int LEN_LO_POS  = 5;
  localparam int LEN_HI_POS  = 6;
  localparam int PAYLOAD_POS = 7;
  localparam int MIN_END     = 8;
  localparam int OVERHEAD    = 13;
  localparam int CRC_LAG     = 6;  // bytes held back from the CRC

  // Digit-serial CRC
  localparam int DIGIT_W         = 2;
  localparam int DIGITS_PER_BYTE = 8 / DIGIT_W;

  // Register map
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic REG_LENGTH_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_CRC_ERR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_CHECK,
    S_EMIT_RD,
    S_EMIT_LOAD,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } crc_ctl_t;

  // Fold DIGIT_W message bits, LSB first, into a reflected CRC
  function automatic logic [15:0] crc_digit(input logic [15:0] crc_in,
                                            input logic [DIGIT_W-1:0] bits);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 0; k < DIGIT_W; k++) begin
      fb = c[0] ^ bits[k];
      c  = (c >> 1) ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

// File: hdl/frame_receiver_crc16_check_core.sv
// Framed packet receiver with CRC-16 check: top level, control and output stage.
// Depends on frc_pkg, frc_ram, frc_crc_digit and the assertion macro header.
//
//  channel | handshake            | word
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | rx_byte
//  output  | out_valid / out_ready| is_status, payload_byte, frame_command,
//          |                      | payload_length, status, last
//  config  | APB psel/penable     | length_limit at byte address 0
//
// A received byte is accepted in S_IDLE, folded in S_FOLD by the 2-bit CRC digit
// unit, which then settles, and checked against the frame rules in S_CHECK.
// The first six bytes of a frame feed no CRC step and do not wait in S_FOLD.
// Payload bytes are read from the registered store in S_EMIT_RD and loaded in
// S_EMIT_LOAD, then one status word. Output stalls hold the sequencer; input waits meanwhile.
// Reset is synchronous; the frame store needs no clearing pass.
`include "frame_receiver_crc16_check_core_assert.svh"

module frame_receiver_crc16_check_core #(
  parameter int STORE_DEPTH = frc_pkg::STORE_DEPTH_DEF,
  parameter int MAX_PAYLOAD = frc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_status,
  output logic [7:0]                  payload_byte,
  output logic [7:0]                  frame_command,
  output logic [5:0]                  payload_length,
  output logic [1:0]                  status,
  output logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frc_pkg::PADDR_W-1:0] paddr,
  input  logic [frc_pkg::PDATA_W-1:0] pwdata,
  output logic [frc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [5:0] MAX_P = 6'(MAX_PAYLOAD);

  frc_pkg::state_t  state, state_next;
  frc_pkg::status_t frame_status, status_reg;
  frc_pkg::crc_ctl_t crc_ctl;

  logic [5:0]       length_limit;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       taps [7];
  logic [7:0]       cmd_byte, len_lo, len_hi;
  logic [5:0]       emit_idx;
  logic [15:0]      crc;
  logic             crc_busy;
  logic [7:0]       rd_data;

  logic accept, out_free, rd_en, load_byte, load_status, restart_en;
  logic sof_ok, eof_hit, sof_bad, store_full, emit_any;
  logic [5:0] limit;
  logic [6:0] rd_pos;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == frc_pkg::REG_LENGTH_LIMIT) ?
                  frc_pkg::PDATA_W'(length_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= frc_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == frc_pkg::REG_LENGTH_LIMIT) begin
      length_limit <= pwdata[5:0];
    end
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  frc_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept),
    .waddr(byte_count[ADDR_W-1:0]),
    .wdata(rx_byte),
    .re   (rd_en),
    .raddr(ADDR_W'(rd_pos)),
    .rdata(rd_data)
  );

  assign rd_pos = {1'b0, emit_idx} + 7'(frc_pkg::PAYLOAD_POS);

  // Fold the byte that falls CRC_LAG places behind the newest one
  assign crc_ctl.start = accept && (byte_count >= CNT_W'(frc_pkg::CRC_LAG));
  assign crc_ctl.clear = restart_en;

  frc_crc_digit u_crc (
    .clk      (clk),
    .rst      (rst),
    .ctl      (crc_ctl),
    .data_byte(taps[5]),
    .crc      (crc),
    .busy     (crc_busy)
  );

  // Frame checks on the tap line, valid in the check state
  always_comb begin
    sof_ok  = 1'b1;
    eof_hit = 1'b1;
    for (int k = 0; k < frc_pkg::SOF_LEN; k++) begin
      sof_ok  = sof_ok && (taps[k] == frc_pkg::SOF_BYTE);
      eof_hit = eof_hit && (taps[k] == frc_pkg::EOF_BYTE);
    end
    eof_hit    = eof_hit && (byte_count >= CNT_W'(frc_pkg::MIN_END));
    sof_bad    = (byte_count == CNT_W'(frc_pkg::SOF_LEN)) && !sof_ok;
    store_full = (byte_count == CNT_W'(STORE_DEPTH));
    limit      = (length_limit < MAX_P) ? length_limit : MAX_P;
    if (len_hi != 8'd0 || len_lo > {2'b00, limit} ||
        byte_count < CNT_W'(frc_pkg::OVERHEAD)) begin
      frame_status = frc_pkg::ST_LEN_ERR;
    end else if (CMP_W'(len_lo) >
                 CMP_W'(byte_count - CNT_W'(frc_pkg::OVERHEAD))) begin
      frame_status = frc_pkg::ST_LEN_ERR;
    end else if ({taps[4], taps[5]} != crc) begin
      frame_status = frc_pkg::ST_CRC_ERR;
    end else begin
      frame_status = frc_pkg::ST_OK;
    end
    emit_any = (frame_status == frc_pkg::ST_OK) && (len_lo != 8'd0);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      frc_pkg::S_IDLE: begin
        if (accept) state_next = frc_pkg::S_FOLD;
      end
      frc_pkg::S_FOLD: begin
        if (!crc_busy) state_next = frc_pkg::S_CHECK;
      end
      frc_pkg::S_CHECK: begin
        if (sof_bad) begin
          state_next = frc_pkg::S_IDLE;
        end else if (eof_hit) begin
          state_next = emit_any ? frc_pkg::S_EMIT_RD : frc_pkg::S_STATUS;
        end else begin
          state_next = frc_pkg::S_IDLE;
        end
      end
      frc_pkg::S_EMIT_RD: begin
        state_next = frc_pkg::S_EMIT_LOAD;
      end
      frc_pkg::S_EMIT_LOAD: begin
        if (out_free) begin
          state_next = (emit_idx == len_lo[5:0] - 6'd1) ?
                       frc_pkg::S_STATUS : frc_pkg::S_EMIT_RD;
        end
      end
      frc_pkg::S_STATUS: begin
        if (out_free) state_next = frc_pkg::S_IDLE;
      end
      default: state_next = frc_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    load_byte   = 1'b0;
    load_status = 1'b0;
    restart_en  = 1'b0;
    case (state)
      frc_pkg::S_IDLE:      in_ready = 1'b1;
      frc_pkg::S_FOLD:      ;
      frc_pkg::S_CHECK:     restart_en = sof_bad || (!eof_hit && store_full);
      frc_pkg::S_EMIT_RD:   rd_en = 1'b1;
      frc_pkg::S_EMIT_LOAD: load_byte = out_free;
      frc_pkg::S_STATUS: begin
        load_status = out_free;
        restart_en  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= frc_pkg::S_IDLE;
      byte_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (restart_en) begin
        byte_count <= '0;
      end else if (accept) begin
        byte_count <= byte_count + CNT_W'(1);
      end
      if (load_byte || load_status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: tap line, header capture, emit index, output word
  always_ff @(posedge clk) begin
    if (accept) begin
      taps[0] <= rx_byte;
      for (int k = 1; k < 7; k++) begin
        taps[k] <= taps[k-1];
      end
      if (byte_count == CNT_W'(frc_pkg::CMD_POS))    cmd_byte <= rx_byte;
      if (byte_count == CNT_W'(frc_pkg::LEN_LO_POS)) len_lo   <= rx_byte;
      if (byte_count == CNT_W'(frc_pkg::LEN_HI_POS)) len_hi   <= rx_byte;
    end
    if (state == frc_pkg::S_CHECK) begin
      status_reg <= frame_status;
      emit_idx   <= '0;
    end else if (load_byte) begin
      emit_idx <= emit_idx + 6'd1;
    end
    if (load_byte) begin
      is_status      <= 1'b0;
      payload_byte   <= rd_data;
      frame_command  <= 8'd0;
      payload_length <= 6'd0;
      status         <= frc_pkg::ST_OK;
      last           <= 1'b0;
    end else if (load_status) begin
      is_status      <= 1'b1;
      payload_byte   <= 8'd0;
      frame_command  <= cmd_byte;
      payload_length <= (len_hi != 8'd0 || len_lo > {2'b00, frc_pkg::LEN_SAT}) ?
                        frc_pkg::LEN_SAT : len_lo[5:0];
      status         <= status_reg;
      last           <= 1'b1;
    end
  end

  `FRC_ASSERT(a_accept_to_fold, clk, rst, accept |=> state == frc_pkg::S_FOLD)
  `FRC_ASSERT(a_crc_only_fold, clk, rst, crc_busy |-> state == frc_pkg::S_FOLD)
  `FRC_ASSERT(a_status_word, clk, rst,
              load_status |=> out_valid && is_status && last)
  `FRC_ASSERT(a_byte_word, clk, rst,
              load_byte |=> out_valid && !is_status && !last)
  `FRC_ASSERT_ALWAYS(a_count_bound, clk,
                     !rst |-> byte_count <= CNT_W'(STORE_DEPTH))

endmodule

// File: hdl/frc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module frc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/frc_crc_digit.sv
// Digit-serial CRC-16 unit: folds one byte, DIGIT_W bits per cycle.
// Depends on frc_pkg.
module frc_crc_digit (
  input  logic            clk,
  input  logic            rst,
  input  frc_pkg::crc_ctl_t ctl,
  input  logic [7:0]      data_byte,
  output logic [15:0]     crc,
  output logic            busy
);

  localparam int CNT_W = $clog2(frc_pkg::DIGITS_PER_BYTE);

  logic [7:0]       sh;
  logic [CNT_W-1:0] digit_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= frc_pkg::CRC_INIT;
      busy      <= 1'b0;
      digit_cnt <= '0;
    end else if (ctl.clear) begin
      crc  <= frc_pkg::CRC_INIT;
      busy <= 1'b0;
    end else if (ctl.start) begin
      sh        <= data_byte;
      busy      <= 1'b1;
      digit_cnt <= '0;
    end else if (busy) begin
      crc       <= frc_pkg::crc_digit(crc, sh[frc_pkg::DIGIT_W-1:0]);
      sh        <= sh >> frc_pkg::DIGIT_W;
      digit_cnt <= digit_cnt + CNT_W'(1);
      if (digit_cnt == CNT_W'(frc_pkg::DIGITS_PER_BYTE - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
